// ===== rtl/fpc_pkg.sv =====
// Shared types, constants and lookup functions for the first-person camera block.
`default_nettype none

package fpc_pkg;

	localparam int unsigned CORDIC_STEPS_DEF = 16;
	localparam int unsigned TAB_IDX_W        = 5;
	localparam int unsigned PRESCALE_SH      = 20;

	typedef logic signed [55:0] cvec_t;
	typedef logic signed [20:0] cang_t;

	typedef struct packed {
		logic start;
		logic vec;
	} cordic_ctl_t;

	typedef enum logic [0:0] {
		CFG_MOUSE_GAIN = 1'b0,
		CFG_WALK_SPEED = 1'b1
	} cfg_idx_e;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_MUL_DX,
		ST_MUL_DY,
		ST_PITCH,
		ST_WRAP,
		ST_WRAP_FIN,
		ST_LD_YAW,
		ST_LD_YAW_WAIT,
		ST_H0,
		ST_H1,
		ST_H2,
		ST_H3,
		ST_LD_PITCH,
		ST_LD_PITCH_WAIT,
		ST_ROT_YAW,
		ST_ROT_YAW_WAIT,
		ST_STEP_M,
		ST_STEP,
		ST_MV_A,
		ST_MV_B,
		ST_MV_C,
		ST_ROT_P,
		ST_ROT_P_WAIT,
		ST_FX,
		ST_FZ,
		ST_FIN
	} state_e;

	localparam cvec_t               K_Q30       = 56'sd652032874;
	localparam logic [15:0]         K_Q16       = 16'd39797;
	localparam cang_t               PI16        = 21'sd205887;
	localparam cang_t               HALF_PI16   = 21'sd102944;
	localparam logic signed [15:0]  PI13        = 16'sd25736;
	localparam logic [15:0]         WRAP_MOD    = 16'd51472;
	localparam logic [3:0]          WRAP_TOP    = 4'd12;
	localparam logic signed [15:0]  PITCH_MAX   = 16'sd12725;
	localparam logic [15:0]         GAIN_RST    = 16'd128;
	localparam logic [31:0]         SPEED_RST   = 32'd327680;

	// arctan(2^-i) in Q16 radians
	function automatic logic [16:0] atan_q16(input logic [TAB_IDX_W-1:0] i);
		logic [16:0] r;
		case (i)
			5'd0:    r = 17'd51472;
			5'd1:    r = 17'd30386;
			5'd2:    r = 17'd16055;
			5'd3:    r = 17'd8150;
			5'd4:    r = 17'd4091;
			5'd5:    r = 17'd2047;
			5'd6:    r = 17'd1024;
			5'd7:    r = 17'd512;
			5'd8:    r = 17'd256;
			5'd9:    r = 17'd128;
			5'd10:   r = 17'd64;
			5'd11:   r = 17'd32;
			5'd12:   r = 17'd16;
			5'd13:   r = 17'd8;
			5'd14:   r = 17'd4;
			5'd15:   r = 17'd2;
			5'd16:   r = 17'd1;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	// length correction for one, two or three active axes (Q16)
	function automatic logic [16:0] norm_q16(input logic [1:0] n);
		logic [16:0] r;
		case (n)
			2'd1:    r = 17'd65536;
			2'd2:    r = 17'd46341;
			2'd3:    r = 17'd37837;
			default: r = 17'd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647)       r = 32'sh7FFFFFFF;
		else if (v < -36'sd2147483648) r = 32'sh80000000;
		else                           r = v[31:0];
		return r;
	endfunction

	function automatic logic signed [15:0] clamp_pitch(input logic signed [29:0] v);
		logic signed [15:0] r;
		if (v > 30'(PITCH_MAX))       r = PITCH_MAX;
		else if (v < -30'(PITCH_MAX)) r = -PITCH_MAX;
		else                          r = v[15:0];
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/fpc_if.sv =====
// Channel interfaces: input items, result items and the configuration write port.
`default_nettype none

interface fpc_in_if;
	logic               valid;
	logic               ready;
	logic               opcode;
	logic signed [15:0] mouse_dx;
	logic signed [15:0] mouse_dy;
	logic [5:0]         keys;
	logic [15:0]        frame_time;
	logic signed [31:0] load_pos_x;
	logic signed [31:0] load_pos_y;
	logic signed [31:0] load_pos_z;
	logic signed [31:0] load_tgt_x;
	logic signed [31:0] load_tgt_y;
	logic signed [31:0] load_tgt_z;

	modport source (output valid, opcode, mouse_dx, mouse_dy, keys, frame_time,
		load_pos_x, load_pos_y, load_pos_z, load_tgt_x, load_tgt_y, load_tgt_z,
		input ready);
	modport sink (input valid, opcode, mouse_dx, mouse_dy, keys, frame_time,
		load_pos_x, load_pos_y, load_pos_z, load_tgt_x, load_tgt_y, load_tgt_z,
		output ready);
endinterface

interface fpc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;
	logic signed [31:0] look_x;
	logic signed [31:0] look_y;
	logic signed [31:0] look_z;
	logic signed [15:0] yaw_out;
	logic signed [14:0] pitch_out;

	modport source (output valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
		yaw_out, pitch_out, input ready);
	modport sink (input valid, pos_x, pos_y, pos_z, look_x, look_y, look_z,
		yaw_out, pitch_out, output ready);
endinterface

interface fpc_cfg_if;
	logic        valid;
	logic        ready;
	logic [0:0]  index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/fpc_cordic.sv =====
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring mode.
`default_nettype none

module fpc_cordic #(
	parameter int unsigned STEPS = fpc_pkg::CORDIC_STEPS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fpc_pkg::cordic_ctl_t ctl,
	input  fpc_pkg::cvec_t      x0,
	input  fpc_pkg::cvec_t      y0,
	input  fpc_pkg::cang_t      z0,
	output fpc_pkg::cvec_t      x,
	output fpc_pkg::cvec_t      y,
	output fpc_pkg::cang_t      z,
	output logic                done
);
	import fpc_pkg::*;

	localparam int unsigned CNT_W = $clog2(STEPS);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q, done_q, vec_q;
	cvec_t            x_q, y_q, xs, ys;
	cang_t            z_q, at;
	logic             up;

	assign xs = x_q >>> cnt_q;
	assign ys = y_q >>> cnt_q;
	assign at = cang_t'(atan_q16(TAB_IDX_W'(cnt_q)));
	// vectoring steers y toward zero, rotation steers z toward zero
	assign up = vec_q ? !(y_q > 0) : (z_q >= 0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			vec_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				vec_q  <= ctl.vec;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			x_q <= x0;
			y_q <= y0;
			z_q <= z0;
		end else if (busy_q) begin
			if (up) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
	assign done = done_q;

endmodule

`default_nettype wire

// ===== rtl/first_person_camera_update_top.sv =====
// Top level of the first-person yaw/pitch camera: sequencer, shared multiplier, pose state.
//
//  channel   dir  handshake      carries
//  -------   ---  -------------  ---------------------------------------------
//  item_in   in   valid/ready    opcode, mouse deltas, keys, frame time, load pose
//  item_out  out  valid/ready    position, look point, yaw, pitch
//  cfg       in   valid/ready    register index and write data (always ready)
//
// Each item runs on one sequencer that drives a single 34x34 multiplier and one
// iterative CORDIC unit; the CORDIC runs set the cost. An update item makes two
// CORDIC runs, a load item up to four.
// item_in is ready only in the idle state. A finished item sits in the output
// register; the next item is accepted meanwhile and stalls at its end only if
// the previous result still has not been taken. Reset clears the pose and loads the configuration defaults.
`default_nettype none

module first_person_camera_update_top #(
	parameter int unsigned CORDIC_STEPS = fpc_pkg::CORDIC_STEPS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	fpc_in_if.sink    item_in,
	fpc_out_if.source item_out,
	fpc_cfg_if.sink   cfg
);
	import fpc_pkg::*;

	state_e state_q, state_d;

	// configuration
	logic [15:0] gain_q;
	logic [31:0] speed_q;

	// architectural pose
	logic signed [15:0] yaw_q, pitch_q;
	logic signed [31:0] pos_q [3];

	// latched item and work registers
	logic               op_q;
	logic signed [15:0] mdx_q, mdy_q;
	logic [5:0]         keys_q;
	logic [15:0]        dt_q;
	logic signed [32:0] dx_q, dy_q, dz_q;
	logic               wneg_q;
	logic [28:0]        wmag_q;
	logic [3:0]         wk_q;
	logic               rneg_q;
	logic signed [33:0] sy_q, cy_q, sp_q, cp_q;
	cvec_t              h_q;
	logic [32:0]        step_q;
	logic [1:0]         comp_q;
	logic signed [31:0] lookx_q;

	// shared multiplier
	logic signed [33:0] mul_a, mul_b;
	logic signed [67:0] mult_q;

	// CORDIC hookup
	cordic_ctl_t cctl;
	cvec_t       c_x0, c_y0, c_x, c_y;
	cang_t       c_z0, c_z;
	logic        c_done;

	// output register
	logic               out_valid_q;
	logic signed [31:0] o_pos_x_q, o_pos_y_q, o_pos_z_q;
	logic signed [31:0] o_look_x_q, o_look_y_q, o_look_z_q;
	logic signed [15:0] o_yaw_q;
	logic signed [14:0] o_pitch_q;

	logic in_acc, out_load;

	assign item_in.ready = (state_q == ST_IDLE);
	assign in_acc        = item_in.valid && item_in.ready;
	assign cfg.ready     = 1'b1;

	fpc_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (cctl),
		.x0     (c_x0),
		.y0     (c_y0),
		.z0     (c_z0),
		.x      (c_x),
		.y      (c_y),
		.z      (c_z),
		.done   (c_done)
	);

	// ---- rounded views of the multiplier and CORDIC results ----
	logic signed [67:0] mq_r3, mq_r16, mq_r44, step_sum;
	cang_t              cz_r3;

	assign mq_r3    = (mult_q + 68'sd4) >>> 3;
	assign mq_r16   = (mult_q + 68'sd32768) >>> 16;
	assign mq_r44   = (mult_q + (68'sd1 <<< 43)) >>> 44;
	assign step_sum = mult_q + 68'sd32768;
	assign cz_r3    = (c_z + 21'sd4) >>> 3;

	// ---- angle wrap: fold into [-pi, pi) by shift-and-subtract ----
	logic signed [29:0] w_upd, w_ld, w_sel, p_upd, p_ld;
	logic [28:0]        wsub;
	logic [15:0]        wr16, yabs;
	logic signed [16:0] ywrap;

	assign w_upd = 30'(yaw_q) + 30'(mq_r3) + 30'(PI13);
	assign w_ld  = 30'(cz_r3) + 30'(PI13);
	assign w_sel = (state_q == ST_MUL_DY) ? w_upd : w_ld;
	assign p_upd = 30'(pitch_q) - 30'(mq_r3);
	assign p_ld  = 30'(cz_r3);
	assign wsub  = 29'(WRAP_MOD) << wk_q;
	assign wr16  = wmag_q[15:0];
	assign yabs  = (wneg_q && (wr16 != 16'd0)) ? (WRAP_MOD - wr16) : wr16;
	assign ywrap = $signed({1'b0, yabs}) - 17'(PI13);

	// ---- rotation start angle, folded into the right half plane ----
	logic signed [15:0] rot_ang;
	cang_t              rz_raw, rz;
	logic               rz_neg;

	assign rot_ang = (state_q == ST_ROT_YAW) ? yaw_q : pitch_q;
	assign rz_raw  = cang_t'(rot_ang) <<< 3;

	always_comb begin
		rz     = rz_raw;
		rz_neg = 1'b0;
		if (rz_raw > HALF_PI16) begin
			rz     = rz_raw - PI16;
			rz_neg = 1'b1;
		end else if (rz_raw < -HALF_PI16) begin
			rz     = rz_raw + PI16;
			rz_neg = 1'b1;
		end
	end

	// ---- load: vectoring start for yaw, half turn when dz is negative ----
	logic  dxz_nz, d_nz;
	cvec_t lx_raw, ly_raw, ly_x, ly_y;
	cang_t ly_z;

	assign dxz_nz = (dx_q != 33'sd0) || (dz_q != 33'sd0);
	assign d_nz   = dxz_nz || (dy_q != 33'sd0);
	assign lx_raw = cvec_t'(dz_q) <<< PRESCALE_SH;
	assign ly_raw = cvec_t'(dx_q) <<< PRESCALE_SH;
	assign ly_x   = (dz_q < 0) ? -lx_raw : lx_raw;
	assign ly_y   = (dz_q < 0) ? -ly_raw : ly_raw;
	assign ly_z   = (dz_q < 0) ? ((dx_q >= 0) ? PI16 : -PI16) : cang_t'(0);

	// ---- movement direction from keys ----
	logic               a_pos, a_neg, b_pos, b_neg, c_pos, c_neg;
	logic [1:0]         nax;
	logic signed [19:0] hs, hc;
	logic signed [21:0] mx, my, mz, dir;
	logic signed [33:0] sy_rnd, cy_rnd;

	assign a_pos = keys_q[0] & ~keys_q[1];
	assign a_neg = keys_q[1] & ~keys_q[0];
	assign b_pos = keys_q[2] & ~keys_q[3];
	assign b_neg = keys_q[3] & ~keys_q[2];
	assign c_pos = keys_q[4] & ~keys_q[5];
	assign c_neg = keys_q[5] & ~keys_q[4];
	assign nax   = 2'(a_pos | a_neg) + 2'(b_pos | b_neg) + 2'(c_pos | c_neg);

	assign sy_rnd = (sy_q + 34'sd8192) >>> 14;
	assign cy_rnd = (cy_q + 34'sd8192) >>> 14;
	assign hs     = sy_rnd[19:0];
	assign hc     = cy_rnd[19:0];

	assign mx = (a_pos ? 22'(hs) : (a_neg ? -22'(hs) : 22'sd0))
		+ (b_pos ? 22'(hc) : (b_neg ? -22'(hc) : 22'sd0));
	assign mz = (a_pos ? 22'(hc) : (a_neg ? -22'(hc) : 22'sd0))
		- (b_pos ? 22'(hs) : (b_neg ? -22'(hs) : 22'sd0));
	assign my = c_pos ? 22'sd65536 : (c_neg ? -22'sd65536 : 22'sd0);

	always_comb begin
		case (comp_q)
			2'd0:    dir = mx;
			2'd1:    dir = my;
			default: dir = mz;
		endcase
	end

	// ---- look offsets ----
	logic signed [33:0] sp_rnd;
	assign sp_rnd = (sp_q + 34'sd8192) >>> 14;

	// ---- sequencer: next state, multiplier operands, CORDIC start ----
	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		cctl    = '0;
		c_x0    = K_Q30;
		c_y0    = '0;
		c_z0    = rz;
		unique case (state_q)
			ST_IDLE: begin
				if (item_in.valid) state_d = item_in.opcode ? ST_LD_YAW : ST_MUL_DX;
			end
			ST_MUL_DX: begin
				mul_a   = 34'(mdx_q);
				mul_b   = 34'(gain_q);
				state_d = ST_MUL_DY;
			end
			ST_MUL_DY: begin
				mul_a   = 34'(mdy_q);
				mul_b   = 34'(gain_q);
				state_d = ST_PITCH;
			end
			ST_PITCH: state_d = ST_WRAP;
			ST_WRAP: begin
				if (wk_q == 4'd0) state_d = ST_WRAP_FIN;
			end
			ST_WRAP_FIN: state_d = op_q ? ST_H0 : ST_ROT_YAW;
			ST_LD_YAW: begin
				if (dxz_nz) begin
					cctl.start = 1'b1;
					cctl.vec   = 1'b1;
					c_x0       = ly_x;
					c_y0       = ly_y;
					c_z0       = ly_z;
					state_d    = ST_LD_YAW_WAIT;
				end else begin
					state_d = ST_LD_PITCH;
				end
			end
			ST_LD_YAW_WAIT: begin
				if (c_done) state_d = ST_WRAP;
			end
			ST_H0: begin
				mul_a   = 34'(c_x[15:0]);
				mul_b   = 34'(K_Q16);
				state_d = ST_H1;
			end
			ST_H1: begin
				mul_a   = 34'(c_x[47:16]);
				mul_b   = 34'(K_Q16);
				state_d = ST_H2;
			end
			ST_H2: begin
				mul_a   = 34'(c_x[55:48]);
				mul_b   = 34'(K_Q16);
				state_d = ST_H3;
			end
			ST_H3: state_d = ST_LD_PITCH;
			ST_LD_PITCH: begin
				if (d_nz) begin
					cctl.start = 1'b1;
					cctl.vec   = 1'b1;
					c_x0       = h_q;
					c_y0       = cvec_t'(dy_q) <<< PRESCALE_SH;
					c_z0       = '0;
					state_d    = ST_LD_PITCH_WAIT;
				end else begin
					state_d = ST_ROT_YAW;
				end
			end
			ST_LD_PITCH_WAIT: begin
				if (c_done) state_d = ST_ROT_YAW;
			end
			ST_ROT_YAW: begin
				cctl.start = 1'b1;
				state_d    = ST_ROT_YAW_WAIT;
			end
			ST_ROT_YAW_WAIT: begin
				if (c_done) state_d = (!op_q && (nax != 2'd0)) ? ST_STEP_M : ST_ROT_P;
			end
			ST_STEP_M: begin
				mul_a   = 34'(speed_q);
				mul_b   = 34'(dt_q);
				state_d = ST_STEP;
			end
			ST_STEP: state_d = ST_MV_A;
			ST_MV_A: begin
				mul_a   = 34'(dir);
				mul_b   = 34'(norm_q16(nax));
				state_d = ST_MV_B;
			end
			ST_MV_B: begin
				mul_a   = mq_r16[33:0];
				mul_b   = 34'(step_q);
				state_d = ST_MV_C;
			end
			ST_MV_C: state_d = (comp_q == 2'd2) ? ST_ROT_P : ST_MV_A;
			ST_ROT_P: begin
				cctl.start = 1'b1;
				state_d    = ST_ROT_P_WAIT;
			end
			ST_ROT_P_WAIT: begin
				if (c_done) state_d = ST_FX;
			end
			ST_FX: begin
				mul_a   = sy_q;
				mul_b   = cp_q;
				state_d = ST_FZ;
			end
			ST_FZ: begin
				mul_a   = cy_q;
				mul_b   = cp_q;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				// hold cy*cp in the product register until the result moves out
				mul_a = cy_q;
				mul_b = cp_q;
				if (!out_valid_q || item_out.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_load = (state_q == ST_FIN) && (!out_valid_q || item_out.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		mult_q <= mul_a * mul_b;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			speed_q <= SPEED_RST;
		end else if (cfg.valid) begin
			unique case (cfg_idx_e'(cfg.index))
				CFG_MOUSE_GAIN: gain_q  <= cfg.data[15:0];
				CFG_WALK_SPEED: speed_q <= cfg.data;
			endcase
		end
	end

	// pose state: angles and position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q    <= '0;
			pitch_q  <= '0;
			pos_q[0] <= '0;
			pos_q[1] <= '0;
			pos_q[2] <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && item_in.opcode) begin
						pos_q[0] <= item_in.load_pos_x;
						pos_q[1] <= item_in.load_pos_y;
						pos_q[2] <= item_in.load_pos_z;
					end
				end
				ST_PITCH:    pitch_q <= clamp_pitch(p_upd);
				ST_WRAP_FIN: yaw_q   <= ywrap[15:0];
				ST_LD_PITCH_WAIT: begin
					if (c_done) pitch_q <= clamp_pitch(p_ld);
				end
				ST_MV_C: pos_q[comp_q] <= sat32(36'(pos_q[comp_q]) + 36'(mq_r16));
				default: ;
			endcase
		end
	end

	// work registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					op_q   <= item_in.opcode;
					mdx_q  <= item_in.mouse_dx;
					mdy_q  <= item_in.mouse_dy;
					keys_q <= item_in.keys;
					dt_q   <= item_in.frame_time;
					dx_q   <= 33'(item_in.load_tgt_x) - 33'(item_in.load_pos_x);
					dy_q   <= 33'(item_in.load_tgt_y) - 33'(item_in.load_pos_y);
					dz_q   <= 33'(item_in.load_tgt_z) - 33'(item_in.load_pos_z);
				end
			end
			ST_MUL_DY: begin
				wneg_q <= w_sel[29];
				wmag_q <= w_sel[29] ? 29'(-w_sel) : 29'(w_sel);
				wk_q   <= WRAP_TOP;
			end
			ST_WRAP: begin
				if (wmag_q >= wsub) wmag_q <= wmag_q - wsub;
				wk_q <= wk_q - 4'd1;
			end
			ST_LD_YAW: begin
				if (!dxz_nz) h_q <= '0;
			end
			ST_LD_YAW_WAIT: begin
				if (c_done) begin
					wneg_q <= w_sel[29];
					wmag_q <= w_sel[29] ? 29'(-w_sel) : 29'(w_sel);
					wk_q   <= WRAP_TOP;
				end
			end
			ST_H1: h_q <= cvec_t'(mult_q[67:16]);
			ST_H2: h_q <= h_q + mult_q[55:0];
			ST_H3: h_q <= h_q + {mult_q[23:0], 32'd0};
			ST_ROT_YAW, ST_ROT_P: rneg_q <= rz_neg;
			ST_ROT_YAW_WAIT: begin
				if (c_done) begin
					sy_q <= rneg_q ? -c_y[33:0] : c_y[33:0];
					cy_q <= rneg_q ? -c_x[33:0] : c_x[33:0];
				end
			end
			ST_STEP: begin
				step_q <= step_sum[48:16];
				comp_q <= 2'd0;
			end
			ST_MV_C: comp_q <= comp_q + 2'd1;
			ST_ROT_P_WAIT: begin
				if (c_done) begin
					sp_q <= rneg_q ? -c_y[33:0] : c_y[33:0];
					cp_q <= rneg_q ? -c_x[33:0] : c_x[33:0];
				end
			end
			ST_FZ: lookx_q <= sat32(36'(pos_q[0]) + 36'(mq_r44));
			default: ;
		endcase
	end

	// result register: valid, then payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                       out_valid_q <= 1'b0;
		else if (out_load)                 out_valid_q <= 1'b1;
		else if (item_out.ready)           out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			o_pos_x_q  <= pos_q[0];
			o_pos_y_q  <= pos_q[1];
			o_pos_z_q  <= pos_q[2];
			o_look_x_q <= lookx_q;
			o_look_y_q <= sat32(36'(pos_q[1]) + 36'(sp_rnd));
			o_look_z_q <= sat32(36'(pos_q[2]) + 36'(mq_r44));
			o_yaw_q    <= yaw_q;
			o_pitch_q  <= pitch_q[14:0];
		end
	end

	assign item_out.valid     = out_valid_q;
	assign item_out.pos_x     = o_pos_x_q;
	assign item_out.pos_y     = o_pos_y_q;
	assign item_out.pos_z     = o_pos_z_q;
	assign item_out.look_x    = o_look_x_q;
	assign item_out.look_y    = o_look_y_q;
	assign item_out.look_z    = o_look_z_q;
	assign item_out.yaw_out   = o_yaw_q;
	assign item_out.pitch_out = o_pitch_q;

endmodule

`default_nettype wire

// ===== tb/first_person_camera_update_top_test.sv =====
// Self-checking testbench for the first-person camera block: directed and random items.
`timescale 1ns / 1ps

module first_person_camera_update_top_test;
	import fpc_pkg::*;

	// One input item as the sender sees it.
	typedef struct {
		bit          opcode;
		bit [15:0]   mouse_dx;
		bit [15:0]   mouse_dy;
		bit [5:0]    keys;
		bit [15:0]   frame_time;
		bit [31:0]   load_pos[3];
		bit [31:0]   load_tgt[3];
	} cam_cmd_t;

	// One result item: position, look point and angles.
	typedef struct {
		bit [31:0] pos[3];
		bit [31:0] look[3];
		bit [15:0] yaw;
		bit [14:0] pitch;
	} cam_pose_t;

	localparam int     CAM_STEPS   = 16;
	localparam longint Q30_GAIN    = 652032874;
	localparam longint Q16_GAIN    = 39797;
	localparam longint ANG_PI      = 25736;
	localparam longint ANG_TWO_PI  = 51472;
	localparam longint ANG_PITCH   = 12725;
	localparam longint CPI         = 205887;
	localparam longint CHALF_PI    = 102944;
	localparam longint VEC_PRESCALE = 1048576;
	localparam int     DRAIN_CYCLES = 200;
	localparam int     STALL_LIMIT  = 20000;
	localparam int     ITEMS_PER_PHASE = 350;

	localparam longint ARCTAN[24] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
		256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
	localparam longint AXIS_NORM[4] = '{0, 65536, 46341, 37837};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fpc_in_if  item_in();
	fpc_out_if item_out();
	fpc_cfg_if cfg();

	first_person_camera_update_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (item_in),
		.item_out (item_out),
		.cfg      (cfg)
	);

	always #5 clk = ~clk;

	// Predicted camera state and registers.
	longint cam_gain, cam_speed;
	longint cam_yaw, cam_pitch;
	longint cam_pos[3];

	cam_cmd_t  pending_cmds[$];
	cam_pose_t expected_poses[$];

	int  errors = 0;
	int  poses_checked = 0;
	int  loads_sent = 0;
	bit  gaps_on = 1'b1;
	bit  hold_off_req = 1'b0;
	int  idle_cycles = 0;

	// ---------------------------------------------------------------- predictor

	function automatic longint round_sh(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint sat_word(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint wrap_yaw(longint t);
		longint r;
		r = (t + ANG_PI) % ANG_TWO_PI;
		if (r < 0) r += ANG_TWO_PI;
		return r - ANG_PI;
	endfunction

	function automatic longint limit_pitch(longint p);
		if (p > ANG_PITCH) return ANG_PITCH;
		if (p < -ANG_PITCH) return -ANG_PITCH;
		return p;
	endfunction

	// cos/sin in Q30 of a Q2.13 angle, by rotation
	function automatic void cos_sin(input longint a13, output longint c, output longint s);
		longint z, x, y, nx;
		bit flip;
		z = a13 * 8;
		x = Q30_GAIN;
		y = 0;
		flip = 1'b0;
		if (z > CHALF_PI) begin
			z -= CPI;
			flip = 1'b1;
		end else if (z < -CHALF_PI) begin
			z += CPI;
			flip = 1'b1;
		end
		for (int i = 0; i < CAM_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARCTAN[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	// drive y to zero; return the angle in Q16, x keeps the gain
	function automatic longint arc_of(inout longint x, input longint y);
		longint z, nx;
		z = 0;
		for (int i = 0; i < CAM_STEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += ARCTAN[i];
			end else begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= ARCTAN[i];
			end
			x = nx;
		end
		return z;
	endfunction

	function automatic cam_pose_t advance_camera(cam_cmd_t c);
		cam_pose_t r;
		longint cy, sy, cp, sp, hs, hc, fwd[3];
		longint a, b, v, nrm, step, mv[3];
		longint d[3], x, y, z0, h;
		int n;
		if (!c.opcode) begin
			cam_yaw = wrap_yaw(cam_yaw +
				round_sh(longint'($signed(c.mouse_dx)) * cam_gain, 3));
			cam_pitch = limit_pitch(cam_pitch -
				round_sh(longint'($signed(c.mouse_dy)) * cam_gain, 3));
			cos_sin(cam_yaw, cy, sy);
			hs = round_sh(sy, 14);
			hc = round_sh(cy, 14);
			a = longint'(c.keys[0]) - longint'(c.keys[1]);
			b = longint'(c.keys[2]) - longint'(c.keys[3]);
			v = longint'(c.keys[4]) - longint'(c.keys[5]);
			n = (a != 0) + (b != 0) + (v != 0);
			if (n != 0) begin
				nrm = AXIS_NORM[n];
				step = (cam_speed * longint'(c.frame_time) + 32768) >>> 16;
				mv[0] = a * hs + b * hc;
				mv[1] = v * 65536;
				mv[2] = a * hc - b * hs;
				for (int k = 0; k < 3; k++)
					cam_pos[k] = sat_word(cam_pos[k] +
						round_sh(round_sh(mv[k] * nrm, 16) * step, 16));
			end
		end else begin
			for (int k = 0; k < 3; k++) begin
				cam_pos[k] = longint'($signed(c.load_pos[k]));
				d[k] = longint'($signed(c.load_tgt[k])) - cam_pos[k];
			end
			h = 0;
			if (d[0] != 0 || d[2] != 0) begin
				x = d[2] * VEC_PRESCALE;
				y = d[0] * VEC_PRESCALE;
				z0 = 0;
				if (x < 0) begin
					z0 = (y >= 0) ? CPI : -CPI;
					x = -x;
					y = -y;
				end
				z0 += arc_of(x, y);
				cam_yaw = wrap_yaw(round_sh(z0, 3));
				h = (x >>> 16) * Q16_GAIN + (((x & 64'hFFFF) * Q16_GAIN) >>> 16);
			end
			if (d[0] != 0 || d[1] != 0 || d[2] != 0)
				cam_pitch = limit_pitch(round_sh(arc_of(h, d[1] * VEC_PRESCALE), 3));
			cos_sin(cam_yaw, cy, sy);
		end
		cos_sin(cam_pitch, cp, sp);
		fwd[0] = round_sh(sy * cp, 44);
		fwd[1] = round_sh(sp, 14);
		fwd[2] = round_sh(cy * cp, 44);
		for (int k = 0; k < 3; k++) begin
			r.pos[k]  = cam_pos[k][31:0];
			r.look[k] = 32'(sat_word(cam_pos[k] + fwd[k]));
		end
		r.yaw   = cam_yaw[15:0];
		r.pitch = cam_pitch[14:0];
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	task automatic report_mismatch(string field, longint got, longint want);
		errors++;
		$display("[%0t] MISMATCH on result %0d, %s: got %0h, expected %0h",
			$time, poses_checked, field, got, want);
	endtask

	// ---------------------------------------------------------------- driver

	int send_hold = 0;

	always @(posedge clk or negedge arst_n) begin
		bit offering;
		cam_cmd_t c;
		if (!arst_n) begin
			item_in.valid <= 1'b0;
		end else begin
			offering = item_in.valid;
			if (item_in.valid && item_in.ready) begin
				// accepted: predict now, then draw the gap before the next item
				expected_poses.push_back(advance_camera(pending_cmds.pop_front()));
				send_hold = gaps_on ? $urandom_range(0, 6) : 0;
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_hold > 0) begin
					send_hold--;
				end else if (pending_cmds.size() != 0) begin
					c = pending_cmds[0];
					item_in.opcode     <= c.opcode;
					item_in.mouse_dx   <= c.mouse_dx;
					item_in.mouse_dy   <= c.mouse_dy;
					item_in.keys       <= c.keys;
					item_in.frame_time <= c.frame_time;
					item_in.load_pos_x <= c.load_pos[0];
					item_in.load_pos_y <= c.load_pos[1];
					item_in.load_pos_z <= c.load_pos[2];
					item_in.load_tgt_x <= c.load_tgt[0];
					item_in.load_tgt_y <= c.load_tgt[1];
					item_in.load_tgt_z <= c.load_tgt[2];
					offering = 1'b1;
				end
			end
			item_in.valid <= offering;
		end
	end

	// ---------------------------------------------------------------- monitor

	int recv_hold = 0;
	int hold_off_left = 0;

	always @(posedge clk or negedge arst_n) begin
		cam_pose_t e;
		bit take;
		if (!arst_n) begin
			item_out.ready <= 1'b0;
		end else begin
			take = item_out.ready;
			if (item_out.valid && item_out.ready) begin
				if (expected_poses.size() == 0) begin
					errors++;
					$display("[%0t] result item arrived with nothing expected", $time);
				end else begin
					e = expected_poses.pop_front();
					if (item_out.pos_x !== e.pos[0]) report_mismatch("pos_x", item_out.pos_x, e.pos[0]);
					if (item_out.pos_y !== e.pos[1]) report_mismatch("pos_y", item_out.pos_y, e.pos[1]);
					if (item_out.pos_z !== e.pos[2]) report_mismatch("pos_z", item_out.pos_z, e.pos[2]);
					if (item_out.look_x !== e.look[0])
						report_mismatch("look_x", item_out.look_x, e.look[0]);
					if (item_out.look_y !== e.look[1])
						report_mismatch("look_y", item_out.look_y, e.look[1]);
					if (item_out.look_z !== e.look[2])
						report_mismatch("look_z", item_out.look_z, e.look[2]);
					if (item_out.yaw_out !== e.yaw)
						report_mismatch("yaw_out", item_out.yaw_out, e.yaw);
					if (item_out.pitch_out !== e.pitch)
						report_mismatch("pitch_out", item_out.pitch_out, e.pitch);
				end
				poses_checked++;
				recv_hold = gaps_on ? $urandom_range(0, 6) : 0;
				take = 1'b0;
			end
			// a requested long hold-off: let the block fill up and stall its input
			if (hold_off_req) begin
				hold_off_left = 600;
				hold_off_req = 1'b0;
			end
			if (hold_off_left > 0) begin
				hold_off_left--;
				take = 1'b0;
			end else if (!take) begin
				if (recv_hold > 0) recv_hold--;
				else take = 1'b1;
			end
			item_out.ready <= take;
		end
	end

	// ---------------------------------------------------------------- watchdog

	always @(posedge clk) begin
		if ((item_in.valid && item_in.ready) || (item_out.valid && item_out.ready) ||
				(cfg.valid && cfg.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ---------------------------------------------------------------- stimulus

	task automatic write_reg(cfg_idx_e idx, bit [31:0] value);
		@(posedge clk);
		cfg.index <= idx;
		cfg.data  <= value;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		if (idx == CFG_MOUSE_GAIN) cam_gain = value[15:0];
		else cam_speed = value;
	endtask

	// wait until every result is back, plus the worst item latency
	task automatic drain();
		wait (pending_cmds.size() == 0 && expected_poses.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic cam_cmd_t move_cmd(bit [15:0] dx, bit [15:0] dy, bit [5:0] k,
			bit [15:0] dt);
		cam_cmd_t c;
		c.opcode = 1'b0;
		c.mouse_dx = dx;
		c.mouse_dy = dy;
		c.keys = k;
		c.frame_time = dt;
		for (int i = 0; i < 3; i++) begin
			c.load_pos[i] = $urandom;
			c.load_tgt[i] = $urandom;
		end
		return c;
	endfunction

	function automatic cam_cmd_t pose_cmd(bit [31:0] px, bit [31:0] py, bit [31:0] pz,
			bit [31:0] tx, bit [31:0] ty, bit [31:0] tz);
		cam_cmd_t c;
		c = move_cmd(16'($urandom), 16'($urandom), 6'($urandom), 16'($urandom));
		c.opcode = 1'b1;
		c.load_pos = '{px, py, pz};
		c.load_tgt = '{tx, ty, tz};
		return c;
	endfunction

	// small coordinate mostly, full range sometimes
	function automatic bit [31:0] rand_coord();
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: return $urandom_range(0, 1) ? 32'h7FFF_0000 + $urandom_range(0, 65535)
				: 32'h8000_0000 + $urandom_range(0, 65535);
			default: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
		endcase
	endfunction

	function automatic cam_cmd_t rand_cmd();
		cam_cmd_t c;
		bit [31:0] p[3];
		if ($urandom_range(0, 9) < 7) begin
			c = move_cmd($urandom_range(0, 3) == 0 ? 16'($urandom)
					: 16'(int'($urandom_range(0, 400)) - 200),
				$urandom_range(0, 3) == 0 ? 16'($urandom)
					: 16'(int'($urandom_range(0, 400)) - 200),
				6'($urandom), 16'($urandom));
		end else begin
			for (int i = 0; i < 3; i++) p[i] = rand_coord();
			c = pose_cmd(p[0], p[1], p[2], rand_coord(), rand_coord(), rand_coord());
			// sometimes aim straight up/down, at the position itself, or with no x offset
			case ($urandom_range(0, 7))
				0: begin c.load_tgt[0] = p[0]; c.load_tgt[2] = p[2]; end
				1: c.load_tgt = c.load_pos;
				2: c.load_tgt[0] = p[0];
				default: ;
			endcase
		end
		return c;
	endfunction

	task automatic run_random(int count);
		for (int i = 0; i < count; i++) begin
			pending_cmds.push_back(rand_cmd());
			if (pending_cmds[$].opcode) loads_sent++;
		end
	endtask

	initial begin
		item_in.valid = 1'b0;
		item_in.opcode = 1'b0;
		item_in.mouse_dx = '0;
		item_in.mouse_dy = '0;
		item_in.keys = '0;
		item_in.frame_time = '0;
		item_in.load_pos_x = '0;
		item_in.load_pos_y = '0;
		item_in.load_pos_z = '0;
		item_in.load_tgt_x = '0;
		item_in.load_tgt_y = '0;
		item_in.load_tgt_z = '0;
		item_out.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = CFG_MOUSE_GAIN;
		cfg.data = '0;
		cam_gain = 128;
		cam_speed = 327680;
		cam_yaw = 0;
		cam_pitch = 0;
		cam_pos = '{0, 0, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset registers, then each key, opposing keys, mouse extremes.
		for (int k = 0; k < 6; k++)
			pending_cmds.push_back(move_cmd(16'd0, 16'd0, 6'(1 << k), 16'd1092));
		pending_cmds.push_back(move_cmd(16'd0, 16'd0, 6'h3F, 16'hFFFF));
		pending_cmds.push_back(move_cmd(16'd0, 16'd0, 6'h15, 16'hFFFF));
		pending_cmds.push_back(move_cmd(16'd0, 16'd0, 6'h05, 16'd0));
		pending_cmds.push_back(move_cmd(16'h7FFF, 16'h7FFF, 6'h01, 16'd1092));
		pending_cmds.push_back(move_cmd(16'h8000, 16'h8000, 6'h09, 16'd1092));
		pending_cmds.push_back(move_cmd(16'h8000, 16'h7FFF, 6'h00, 16'hFFFF));
		drain();
		write_reg(CFG_MOUSE_GAIN, 32'hFFFF);
		write_reg(CFG_WALK_SPEED, 32'hFFFF_FFFF);
		// Position runs into saturation at full speed; loads at the range edges.
		for (int i = 0; i < 4; i++)
			pending_cmds.push_back(move_cmd(16'h7FFF, 16'h8000, 6'h15, 16'hFFFF));
		pending_cmds.push_back(move_cmd(16'h8000, 16'h7FFF, 6'h2A, 16'hFFFF));
		pending_cmds.push_back(pose_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pending_cmds.push_back(pose_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		pending_cmds.push_back(pose_cmd(0, 0, 0, 0, 32'h10000, 0));
		pending_cmds.push_back(pose_cmd(0, 0, 0, 0, 32'hFFFF_0000, 0));
		pending_cmds.push_back(pose_cmd(5, 6, 7, 5, 6, 7));
		pending_cmds.push_back(pose_cmd(0, 0, 0, 0, 0, 32'hFFFF_0000));
		pending_cmds.push_back(pose_cmd(0, 0, 0, 32'hFFFF_FFFF, 0, 32'hFFFF_0000));
		pending_cmds.push_back(pose_cmd(0, 0, 0, 32'h0001_0000, 32'h7FFF_0000, 0));
		loads_sent += 8;
		drain();

		// Random phases over several register settings.
		write_reg(CFG_MOUSE_GAIN, 32'd0);
		write_reg(CFG_WALK_SPEED, 32'd0);
		run_random(ITEMS_PER_PHASE);
		drain();

		write_reg(CFG_MOUSE_GAIN, 32'd128);
		write_reg(CFG_WALK_SPEED, 32'd327680);
		gaps_on = 1'b0;
		run_random(ITEMS_PER_PHASE / 2);
		drain();
		gaps_on = 1'b1;
		hold_off_req = 1'b1;
		run_random(ITEMS_PER_PHASE / 2);
		drain();

		write_reg(CFG_MOUSE_GAIN, $urandom_range(0, 65535));
		write_reg(CFG_WALK_SPEED, $urandom);
		run_random(ITEMS_PER_PHASE);
		drain();

		write_reg(CFG_MOUSE_GAIN, $urandom_range(0, 2048));
		write_reg(CFG_WALK_SPEED, $urandom_range(0, 32'h0100_0000));
		run_random(ITEMS_PER_PHASE);
		drain();

		write_reg(CFG_MOUSE_GAIN, 32'hFFFF);
		write_reg(CFG_WALK_SPEED, 32'hFFFF_FFFF);
		run_random(ITEMS_PER_PHASE);
		drain();

		$display("Checked %0d result items (%0d from pose loads) over a range of register settings,",
			poses_checked, loads_sent);
		$display("with random gaps, gap-free bursts and one long output stall.");
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// ===== first_person_camera_update_top.f =====
rtl/fpc_pkg.sv
rtl/fpc_if.sv
rtl/fpc_cordic.sv
rtl/first_person_camera_update_top.sv
tb/first_person_camera_update_top_test.sv
